/* design/cbpg_pkg.sv */
// ----------------------------------------------------------------------------
// cbpg_pkg
// Shared widths, item types and controller-to-datapath command types for the
// cubic Bezier point generator.
// ----------------------------------------------------------------------------
package cbpg_pkg;

    // field widths
    localparam int COORD_WIDTH = 32;
    localparam int STEP_WIDTH  = 6;
    localparam int MAX_STEPS   = 63;
    localparam int NUM_POINTS  = 4;
    localparam int NUM_AXES    = 3;

    // internal widths: polynomial coefficients, n squared, n cubed, quotients
    localparam int COEF_WIDTH = COORD_WIDTH + 4;
    localparam int SQ_WIDTH   = 2 * STEP_WIDTH;
    localparam int CUBE_WIDTH = 3 * STEP_WIDTH;
    localparam int QUOT_WIDTH = SQ_WIDTH + COEF_WIDTH;

    localparam logic [STEP_WIDTH-1:0] NUM_STEPS_RESET  = STEP_WIDTH'(50);
    localparam logic [1:0]            LAST_POINT_INDEX = 2'd3;

    // which forward difference the per-axis dividers work on
    typedef enum logic [1:0] {
        DIFF_FIRST,
        DIFF_SECOND,
        DIFF_THIRD
    } diff_sel_t;

    typedef struct packed {
        logic [1:0]                    point_index;
        logic signed [COORD_WIDTH-1:0] coord_x;
        logic signed [COORD_WIDTH-1:0] coord_y;
        logic signed [COORD_WIDTH-1:0] coord_z;
    } in_item_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] curve_x;
        logic signed [COORD_WIDTH-1:0] curve_y;
        logic signed [COORD_WIDTH-1:0] curve_z;
        logic [STEP_WIDTH-1:0]         sample_number;
        logic                          last_point;
    } out_item_t;

    typedef struct packed {
        logic                  store;
        logic [1:0]            store_index;
        logic                  load_coef;
        logic                  load_prod;
        logic                  load_diff;
        logic                  div_start;
        diff_sel_t             div_sel;
        logic                  step;
        logic [STEP_WIDTH-1:0] steps;
        logic [STEP_WIDTH-1:0] sample;
        logic                  last;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
    } dp_status_t;

endpackage

/* design/cbpg_div.sv */
// ----------------------------------------------------------------------------
// cbpg_div
// Radix-2 restoring divider: signed dividend by unsigned divisor, giving the
// floor quotient and a remainder in [0, divisor). One quotient bit per cycle.
// ----------------------------------------------------------------------------
module cbpg_div (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic signed [cbpg_pkg::QUOT_WIDTH-1:0] dividend,
    input  logic [cbpg_pkg::CUBE_WIDTH-1:0]        divisor,
    output logic                                   done,
    output logic signed [cbpg_pkg::QUOT_WIDTH-1:0] quotient,
    output logic [cbpg_pkg::CUBE_WIDTH-1:0]        remainder
);
    import cbpg_pkg::*;

    localparam int COUNT_WIDTH = $clog2(QUOT_WIDTH);

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_SHIFT,
        DV_FIX
    } state_t;

    state_t                  state_reg, state_next;
    logic [COUNT_WIDTH-1:0]  count_reg, count_next;
    logic                    neg_reg, neg_next;
    logic [QUOT_WIDTH-1:0]   bits_reg, bits_next;
    logic [CUBE_WIDTH-1:0]   part_reg, part_next;
    logic                    done_reg, done_next;
    logic [QUOT_WIDTH-1:0]   quot_reg, quot_next;
    logic [CUBE_WIDTH-1:0]   rem_reg, rem_next;
    logic [CUBE_WIDTH:0]     trial;
    logic                    fits;

    // one restoring step
    assign trial = {part_reg, bits_reg[QUOT_WIDTH-1]};
    assign fits  = (trial >= {1'b0, divisor});

    // next state and outputs
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        neg_next   = neg_reg;
        bits_next  = bits_reg;
        part_next  = part_reg;
        done_next  = 1'b0;
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        unique case (state_reg)
            DV_IDLE:
            begin
                if (start)
                begin
                    neg_next   = dividend[QUOT_WIDTH-1];
                    bits_next  = dividend[QUOT_WIDTH-1] ? -dividend : dividend;
                    part_next  = '0;
                    count_next = '0;
                    state_next = DV_SHIFT;
                end
            end
            DV_SHIFT:
            begin
                part_next  = fits ? CUBE_WIDTH'(trial - {1'b0, divisor})
                                  : trial[CUBE_WIDTH-1:0];
                bits_next  = {bits_reg[QUOT_WIDTH-2:0], fits};
                count_next = count_reg + COUNT_WIDTH'(1);
                if (count_reg == COUNT_WIDTH'(QUOT_WIDTH - 1))
                begin
                    state_next = DV_FIX;
                end
            end
            DV_FIX:
            begin
                // turn the magnitude result into floor quotient and remainder
                if (neg_reg && (part_reg != '0))
                begin
                    quot_next = ~bits_reg;
                    rem_next  = divisor - part_reg;
                end
                else if (neg_reg)
                begin
                    quot_next = -bits_reg;
                    rem_next  = '0;
                end
                else
                begin
                    quot_next = bits_reg;
                    rem_next  = part_reg;
                end
                done_next  = 1'b1;
                state_next = DV_IDLE;
            end
            default:
            begin
                state_next = DV_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DV_IDLE;
            count_reg <= '0;
            neg_reg   <= 1'b0;
            bits_reg  <= '0;
            part_reg  <= '0;
            done_reg  <= 1'b0;
            quot_reg  <= '0;
            rem_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            neg_reg   <= neg_next;
            bits_reg  <= bits_next;
            part_reg  <= part_next;
            done_reg  <= done_next;
            quot_reg  <= quot_next;
            rem_reg   <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quot_reg;
    assign remainder = rem_reg;

endmodule

/* design/cbpg_datapath.sv */
// ----------------------------------------------------------------------------
// cbpg_datapath
// Control point store, power-basis coefficients, forward differences held as
// exact quotient/remainder pairs over n cubed, one divider per axis, and the
// rounding output register.
// ----------------------------------------------------------------------------
module cbpg_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cbpg_pkg::in_item_t   in_item,
    input  cbpg_pkg::dp_cmd_t    cmd,
    output cbpg_pkg::dp_status_t status,
    output cbpg_pkg::out_item_t  out_item
);
    import cbpg_pkg::*;

    // value = quot * n^3 + rem, with 0 <= rem < n^3
    typedef struct packed {
        logic signed [QUOT_WIDTH-1:0] quot;
        logic [CUBE_WIDTH-1:0]        rem;
    } pair_t;

    // add two pairs, carrying the remainder overflow into the quotient
    function automatic pair_t pair_add(pair_t a, pair_t b, logic [CUBE_WIDTH-1:0] m);
        logic [CUBE_WIDTH:0] sum;
        logic                wrap;
        pair_t               res;
        sum      = {1'b0, a.rem} + {1'b0, b.rem};
        wrap     = (sum >= {1'b0, m});
        res.rem  = wrap ? CUBE_WIDTH'(sum - {1'b0, m}) : sum[CUBE_WIDTH-1:0];
        res.quot = a.quot + b.quot + QUOT_WIDTH'(wrap);
        return res;
    endfunction

    logic [SQ_WIDTH-1:0]           n2_reg;
    logic [CUBE_WIDTH-1:0]         n3_reg;
    logic [CUBE_WIDTH-1:0]         thr_pos_reg;
    logic [CUBE_WIDTH-1:0]         thr_neg_reg;
    logic signed [SQ_WIDTH:0]      n2_signed;
    logic signed [STEP_WIDTH:0]    n_signed;
    logic signed [COORD_WIDTH-1:0] in_coord [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] curve_next [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] curve_reg [NUM_AXES];
    logic [STEP_WIDTH-1:0]         sample_reg;
    logic                          last_reg;
    logic [NUM_AXES-1:0]           div_done_lane;

    assign in_coord[0] = in_item.coord_x;
    assign in_coord[1] = in_item.coord_y;
    assign in_coord[2] = in_item.coord_z;
    assign n2_signed   = {1'b0, n2_reg};
    assign n_signed    = {1'b0, cmd.steps};

    // n squared, n cubed and the rounding thresholds
    always_ff @(posedge clk)
    begin
        if (cmd.load_coef)
        begin
            n2_reg <= cmd.steps * cmd.steps;
        end
        if (cmd.load_prod)
        begin
            n3_reg <= n2_reg * cmd.steps;
        end
        if (cmd.load_diff)
        begin
            thr_pos_reg <= n3_reg - (n3_reg >> 1);
            thr_neg_reg <= (n3_reg >> 1) + CUBE_WIDTH'(1);
        end
    end

    // one lane per axis
    for (genvar a = 0; a < NUM_AXES; a++)
    begin : g_lane
        logic signed [COORD_WIDTH-1:0]         point_reg [NUM_POINTS];
        logic signed [COEF_WIDTH-1:0]          p0, p1, p2, p3;
        logic signed [COEF_WIDTH-1:0]          d10, sec, d12;
        logic signed [COEF_WIDTH-1:0]          c1_reg, c2_reg, c3_reg;
        logic signed [SQ_WIDTH+COEF_WIDTH:0]   prod_sq;
        logic signed [STEP_WIDTH+COEF_WIDTH:0] prod_n;
        logic signed [QUOT_WIDTH-1:0]          t1_reg, t2_reg;
        logic signed [QUOT_WIDTH-1:0]          c3_wide, six_c3;
        logic signed [QUOT_WIDTH-1:0]          d1_reg, d2_reg, d3_reg;
        logic signed [QUOT_WIDTH-1:0]          dividend;
        logic signed [QUOT_WIDTH-1:0]          div_quot;
        logic [CUBE_WIDTH-1:0]                 div_rem;
        pair_t                                 pos_reg, vel_reg, acc_reg, jerk_reg;
        pair_t                                 pos_step, vel_step, acc_step;
        logic [CUBE_WIDTH-1:0]                 thr;
        logic signed [QUOT_WIDTH-1:0]          rounded;

        // sign-extended control points
        assign p0 = {{(COEF_WIDTH-COORD_WIDTH){point_reg[0][COORD_WIDTH-1]}}, point_reg[0]};
        assign p1 = {{(COEF_WIDTH-COORD_WIDTH){point_reg[1][COORD_WIDTH-1]}}, point_reg[1]};
        assign p2 = {{(COEF_WIDTH-COORD_WIDTH){point_reg[2][COORD_WIDTH-1]}}, point_reg[2]};
        assign p3 = {{(COEF_WIDTH-COORD_WIDTH){point_reg[3][COORD_WIDTH-1]}}, point_reg[3]};

        // power-basis terms of the cubic
        assign d10 = p1 - p0;
        assign sec = p0 - (p1 <<< 1) + p2;
        assign d12 = p1 - p2;

        // scaled terms
        assign prod_sq = n2_signed * c1_reg;
        assign prod_n  = n_signed * c2_reg;
        assign c3_wide = QUOT_WIDTH'(c3_reg);
        assign six_c3  = (c3_wide <<< 2) + (c3_wide <<< 1);

        // divider operand select
        always_comb
        begin
            unique case (cmd.div_sel)
                DIFF_FIRST:  dividend = d1_reg;
                DIFF_SECOND: dividend = d2_reg;
                DIFF_THIRD:  dividend = d3_reg;
                default:     dividend = d3_reg;
            endcase
        end

        cbpg_div u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .start     (cmd.div_start),
            .dividend  (dividend),
            .divisor   (n3_reg),
            .done      (div_done_lane[a]),
            .quotient  (div_quot),
            .remainder (div_rem)
        );

        // forward difference step
        assign pos_step = pair_add(pos_reg, vel_reg, n3_reg);
        assign vel_step = pair_add(vel_reg, acc_reg, n3_reg);
        assign acc_step = pair_add(acc_reg, jerk_reg, n3_reg);

        // round half away from zero
        assign thr           = pos_reg.quot[QUOT_WIDTH-1] ? thr_neg_reg : thr_pos_reg;
        assign rounded       = pos_reg.quot + QUOT_WIDTH'(pos_reg.rem >= thr);
        assign curve_next[a] = rounded[COORD_WIDTH-1:0];

        // point store, setup pipeline and difference registers
        always_ff @(posedge clk)
        begin
            if (cmd.store)
            begin
                point_reg[cmd.store_index] <= in_coord[a];
            end
            if (cmd.load_coef)
            begin
                c1_reg <= (d10 <<< 1) + d10;
                c2_reg <= (sec <<< 1) + sec;
                c3_reg <= p3 - p0 + (d12 <<< 1) + d12;
            end
            if (cmd.load_prod)
            begin
                t1_reg <= prod_sq[QUOT_WIDTH-1:0];
                t2_reg <= QUOT_WIDTH'(prod_n);
            end
            if (cmd.load_diff)
            begin
                d1_reg       <= t1_reg + t2_reg + c3_wide;
                d2_reg       <= (t2_reg <<< 1) + six_c3;
                d3_reg       <= six_c3;
                pos_reg.quot <= QUOT_WIDTH'(point_reg[0]);
                pos_reg.rem  <= '0;
            end
            if (div_done_lane[a])
            begin
                unique case (cmd.div_sel)
                    DIFF_FIRST:
                    begin
                        vel_reg.quot <= div_quot;
                        vel_reg.rem  <= div_rem;
                    end
                    DIFF_SECOND:
                    begin
                        acc_reg.quot <= div_quot;
                        acc_reg.rem  <= div_rem;
                    end
                    DIFF_THIRD:
                    begin
                        jerk_reg.quot <= div_quot;
                        jerk_reg.rem  <= div_rem;
                    end
                    default:
                    begin
                        jerk_reg.quot <= div_quot;
                        jerk_reg.rem  <= div_rem;
                    end
                endcase
            end
            else if (cmd.step)
            begin
                pos_reg <= pos_step;
                vel_reg <= vel_step;
                acc_reg <= acc_step;
            end
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                curve_reg[i] <= curve_next[i];
            end
            sample_reg <= cmd.sample;
            last_reg   <= cmd.last;
        end
    end

    assign status.div_done = &div_done_lane;

    assign out_item.curve_x       = curve_reg[0];
    assign out_item.curve_y       = curve_reg[1];
    assign out_item.curve_z       = curve_reg[2];
    assign out_item.sample_number = sample_reg;
    assign out_item.last_point    = last_reg;

endmodule

/* design/cbpg_ctrl.sv */
// ----------------------------------------------------------------------------
// cbpg_ctrl
// Sequencer for the point generator: loads points, runs the setup steps and
// the three divisions, then steps the curve one point per output handshake.
// ----------------------------------------------------------------------------
module cbpg_ctrl (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write_enable,
    input  logic [cbpg_pkg::STEP_WIDTH-1:0]   cfg_write_data,
    input  logic                              in_valid,
    input  logic [1:0]                        in_point_index,
    output logic                              in_stall,
    output logic                              out_valid,
    input  logic                              out_stall,
    output cbpg_pkg::dp_cmd_t                 cmd,
    input  cbpg_pkg::dp_status_t              status
);
    import cbpg_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COEF,
        ST_PROD,
        ST_DIFF,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_RUN
    } state_t;

    state_t                state_reg, state_next;
    logic [STEP_WIDTH-1:0] num_steps_reg, num_steps_next;
    logic [STEP_WIDTH-1:0] n_reg, n_next;
    logic [STEP_WIDTH-1:0] k_reg, k_next;
    diff_sel_t             sel_reg, sel_next;
    logic                  out_valid_reg, out_valid_next;
    logic [STEP_WIDTH-1:0] clamped;
    logic                  accept;
    logic                  advance;
    logic                  run_last;

    assign accept   = in_valid && (state_reg == ST_IDLE);
    assign advance  = (state_reg == ST_RUN) && (!out_valid_reg || !out_stall);
    assign run_last = (k_reg == n_reg);

    // interval count limited to the supported range
    always_comb
    begin
        if (num_steps_reg == '0)
        begin
            clamped = STEP_WIDTH'(1);
        end
        else if (num_steps_reg > STEP_WIDTH'(MAX_STEPS))
        begin
            clamped = STEP_WIDTH'(MAX_STEPS);
        end
        else
        begin
            clamped = num_steps_reg;
        end
    end

    // next state
    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        k_next         = k_reg;
        sel_next       = sel_reg;
        num_steps_next = cfg_write_enable ? cfg_write_data : num_steps_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (in_point_index == LAST_POINT_INDEX))
                begin
                    n_next     = clamped;
                    state_next = ST_COEF;
                end
            end
            ST_COEF:
            begin
                state_next = ST_PROD;
            end
            ST_PROD:
            begin
                state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                sel_next   = DIFF_FIRST;
                state_next = ST_DIV_GO;
            end
            ST_DIV_GO:
            begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (status.div_done)
                begin
                    if (sel_reg == DIFF_THIRD)
                    begin
                        k_next     = '0;
                        state_next = ST_RUN;
                    end
                    else
                    begin
                        sel_next   = (sel_reg == DIFF_FIRST) ? DIFF_SECOND : DIFF_THIRD;
                        state_next = ST_DIV_GO;
                    end
                end
            end
            ST_RUN:
            begin
                if (advance)
                begin
                    k_next = k_reg + STEP_WIDTH'(1);
                    if (run_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register occupancy
    always_comb
    begin
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            num_steps_reg <= NUM_STEPS_RESET;
            n_reg         <= STEP_WIDTH'(1);
            k_reg         <= '0;
            sel_reg       <= DIFF_FIRST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            num_steps_reg <= num_steps_next;
            n_reg         <= n_next;
            k_reg         <= k_next;
            sel_reg       <= sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // commands to the datapath
    assign cmd.store       = accept;
    assign cmd.store_index = in_point_index;
    assign cmd.load_coef   = (state_reg == ST_COEF);
    assign cmd.load_prod   = (state_reg == ST_PROD);
    assign cmd.load_diff   = (state_reg == ST_DIFF);
    assign cmd.div_start   = (state_reg == ST_DIV_GO);
    assign cmd.div_sel     = sel_reg;
    assign cmd.step        = advance;
    assign cmd.steps       = n_reg;
    assign cmd.sample      = k_reg;
    assign cmd.last        = run_last;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

/* design/cubic_bezier_point_generator.sv */
// Cubic Bezier point generator. Send the four control points P0..P3 as items
// (point_index 0..3, signed Q16.16 x, y, z); an item for points 0 to 2 is
// stored, and the item for point 3 is stored and starts a run that returns
// num_steps+1 curve points at u = k/num_steps, each rounded to nearest with
// ties away from zero, the final one flagged by last_point. num_steps is set
// through the write port (reset 50, 0 acts as 1). A run begins with setup,
// chiefly the three divisions per axis that put the forward differences of
// the curve polynomial over n cubed, and then gives one point per cycle from
// the forward-difference loop while the output is not stalled. No new item
// is taken until the last point of the run has entered the output register.

// ----------------------------------------------------------------------------
// cubic_bezier_point_generator
// Top level: controller and datapath of the cubic Bezier point generator.
// ----------------------------------------------------------------------------
module cubic_bezier_point_generator (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write_enable,
    input  logic [cbpg_pkg::STEP_WIDTH-1:0] cfg_write_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  cbpg_pkg::in_item_t              in_item,
    output logic                            out_valid,
    input  logic                            out_stall,
    output cbpg_pkg::out_item_t             out_item
);
    import cbpg_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencer
    cbpg_ctrl u_ctrl (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .in_valid         (in_valid),
        .in_point_index   (in_item.point_index),
        .in_stall         (in_stall),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .cmd              (cmd),
        .status           (status)
    );

    // arithmetic
    cbpg_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (in_item),
        .cmd      (cmd),
        .status   (status),
        .out_item (out_item)
    );

endmodule

/* design/cbpg_checker.sv */
// ----------------------------------------------------------------------------
// cbpg_checker
// Port-level checks for the cubic Bezier point generator, bound to the top.
// ----------------------------------------------------------------------------
module cbpg_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_stall,
    input cbpg_pkg::in_item_t              in_item,
    input logic                            out_valid,
    input logic                            out_stall,
    input cbpg_pkg::out_item_t             out_item
);
    import cbpg_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("result item changed while stalled");

    // while a run is still emitting, no input item is taken
    a_busy_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_item.last_point |-> in_stall)
        else $error("input open before the run finished");

    // loading the last control point starts a run
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (in_item.point_index == LAST_POINT_INDEX) |=> in_stall)
        else $error("run did not start after the last control point");

    // a run always has at least one interval
    a_last_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.last_point |-> out_item.sample_number != '0)
        else $error("final point flagged at sample zero");

endmodule

bind cubic_bezier_point_generator cbpg_checker u_cbpg_checker (.*);

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the cubic Bezier point generator. Control points
// go in one item at a time; every point-3 item is expanded here into the full
// run of expected curve points (exact Bernstein sums over n cubed, rounded to
// nearest with ties away from zero) and compared field by field with what the
// block returns. A short table of hand-picked items comes first, then random
// load sequences over several step settings with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cbpg_pkg::*;

    localparam int     WATCHDOG_LIMIT = 4000;
    localparam int     SETTLE_CYCLES  = 240;
    localparam int     HOLD_CYCLES    = 400;
    localparam int     MAX_REPORTS    = 30;
    localparam int     NUM_PHASES     = 12;
    localparam int     PHASE_ITEMS    = 37;
    localparam int     RANDOM_STEPS   = 99;
    localparam longint BINOM_MID      = 3;

    localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    // shapes of random coordinates
    typedef enum int {
        COORD_FULL,
        COORD_TINY,
        COORD_EXTREME,
        COORD_MODERATE
    } coord_mode_t;

    typedef struct {
        in_item_t                      item;
        bit                            typed;
        logic signed [COORD_WIDTH-1:0] typed_val;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write_enable = 1'b0;
    logic [STEP_WIDTH-1:0] cfg_write_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    in_item_t in_item = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_item_t out_item;

    // bench-side copy of the block state
    logic signed [COORD_WIDTH-1:0] ctrl_pts [NUM_POINTS][NUM_AXES];
    logic [STEP_WIDTH-1:0]         cur_steps = NUM_STEPS_RESET;
    out_item_t                     expected_points [$];
    dir_row_t                      dir_rows [$];

    int  error_count    = 0;
    int  items_sent     = 0;
    int  runs_started   = 0;
    int  points_checked = 0;
    int  quiet_cycles   = 0;
    bit  hold_req       = 1'b0;
    bit  send_gaps      = 1'b0;
    bit  recv_gaps      = 1'b0;
    bit  no_idle        = 1'b0;

    cubic_bezier_point_generator dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .in_item          (in_item),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .out_item         (out_item)
    );

    always #5 clk = ~clk;

    // rounding to nearest, ties away from zero
    function automatic longint round_nearest(input longint num, input longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (mag + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    // store one control point; point 3 expands into the whole run of curve points
    function automatic void take_control_point(input in_item_t it, input bit typed,
                                               input logic signed [COORD_WIDTH-1:0] typed_val);
        longint    n;
        longint    m;
        longint    acc;
        longint    w [NUM_POINTS];
        out_item_t pt;
        ctrl_pts[it.point_index][0] = it.coord_x;
        ctrl_pts[it.point_index][1] = it.coord_y;
        ctrl_pts[it.point_index][2] = it.coord_z;
        if (it.point_index != LAST_POINT_INDEX)
            return;
        runs_started++;
        n = (cur_steps == 0) ? 1 : longint'(cur_steps);
        if (n > MAX_STEPS)
            n = MAX_STEPS;
        for (longint k = 0; k <= n; k++)
        begin
            m = n - k;
            w[0] = m * m * m;
            w[1] = BINOM_MID * k * m * m;
            w[2] = BINOM_MID * k * k * m;
            w[3] = k * k * k;
            for (int a = 0; a < NUM_AXES; a++)
            begin
                acc = 0;
                for (int p = 0; p < NUM_POINTS; p++)
                    acc += w[p] * longint'(ctrl_pts[p][a]);
                acc = typed ? longint'(typed_val) : round_nearest(acc, n * n * n);
                case (a)
                    0: pt.curve_x = acc[COORD_WIDTH-1:0];
                    1: pt.curve_y = acc[COORD_WIDTH-1:0];
                    default: pt.curve_z = acc[COORD_WIDTH-1:0];
                endcase
            end
            pt.sample_number = k[STEP_WIDTH-1:0];
            pt.last_point = (k == n);
            expected_points = {expected_points, pt};
        end
    endfunction

    function automatic void flag_field(input string name, input longint want, input longint got);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    endfunction

    function automatic logic signed [COORD_WIDTH-1:0] rand_coord(input coord_mode_t mode);
        case (mode)
            COORD_FULL:
                return $urandom;
            COORD_TINY:
                return $signed($urandom_range(0, 16)) - 8;
            COORD_EXTREME:
                case ($urandom_range(0, 3))
                    0: return COORD_MAX;
                    1: return COORD_MIN;
                    2: return '0;
                    default: return '1;
                endcase
            default:
                return $signed($urandom_range(0, 2 ** 21)) - 2 ** 20;
        endcase
    endfunction

    function automatic in_item_t make_point(input logic [1:0] idx, input coord_mode_t mode);
        in_item_t it;
        it.point_index = idx;
        it.coord_x = rand_coord(mode);
        it.coord_y = rand_coord(mode);
        it.coord_z = rand_coord(mode);
        return it;
    endfunction

    function automatic void add_row(input logic [1:0] idx, input logic signed [COORD_WIDTH-1:0] x,
                                    input logic signed [COORD_WIDTH-1:0] y,
                                    input logic signed [COORD_WIDTH-1:0] z,
                                    input bit typed, input logic signed [COORD_WIDTH-1:0] val);
        dir_row_t r;
        r.item = '{point_index: idx, coord_x: x, coord_y: y, coord_z: z};
        r.typed = typed;
        r.typed_val = val;
        dir_rows = {dir_rows, r};
    endfunction

    // offer one item, optionally after a random gap, and wait for it to be taken
    task automatic send_item(input in_item_t it, input bit typed,
                             input logic signed [COORD_WIDTH-1:0] typed_val);
        int gap;
        gap = (send_gaps && !no_idle && $urandom_range(0, 4) == 0) ? $urandom_range(1, 10) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        forever
        begin
            @(posedge clk);
            if (!in_stall)
                break;
        end
        items_sent++;
        take_control_point(it, typed, typed_val);
    endtask

    // sender pauses until every curve point is back and the block has gone quiet
    task automatic drain_and_settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_points.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_steps(input logic [STEP_WIDTH-1:0] value);
        @(negedge clk);
        cfg_write_enable <= 1'b1;
        cfg_write_data <= value;
        @(negedge clk);
        cfg_write_enable <= 1'b0;
        cur_steps = value;
    endtask

    // one random burst of items: mostly complete loads, some noise and broken loads
    task automatic send_random_group();
        coord_mode_t mode;
        int          pick;
        int          len;
        mode = coord_mode_t'($urandom_range(0, 3));
        pick = $urandom_range(0, 9);
        if (pick < 7)
        begin
            for (int p = 0; p < NUM_POINTS; p++)
                send_item(make_point(p[1:0], mode), 1'b0, '0);
        end
        else if (pick == 7)
            send_item(make_point(2'($urandom_range(0, 3)), mode), 1'b0, '0);
        else if (pick == 8)
        begin
            len = $urandom_range(1, 3);
            for (int i = 0; i < len; i++)
                send_item(make_point(2'($urandom_range(0, 2)), mode), 1'b0, '0);
            send_item(make_point(LAST_POINT_INDEX, mode), 1'b0, '0);
        end
        else
            send_item(make_point(LAST_POINT_INDEX, mode), 1'b0, '0);
    endtask

    // receiver: random stall bursts, plus one long hold-off on request
    initial
    begin
        int hold_left;
        int burst_left;
        hold_left = 0;
        burst_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (burst_left > 0)
            begin
                out_stall <= 1'b1;
                burst_left--;
            end
            else if (recv_gaps && !no_idle && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b1;
                burst_left = $urandom_range(1, 10) - 1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // result checking and watchdog
    always @(posedge clk)
    begin : check_out
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_points.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected curve point, expected none, actual x=%0d y=%0d z=%0d k=%0d",
                         $time, out_item.curve_x, out_item.curve_y, out_item.curve_z,
                         out_item.sample_number);
            end
            else
            begin
                want = expected_points.pop_front();
                points_checked++;
                if (out_item.curve_x !== want.curve_x)
                    flag_field("curve_x", want.curve_x, out_item.curve_x);
                if (out_item.curve_y !== want.curve_y)
                    flag_field("curve_y", want.curve_y, out_item.curve_y);
                if (out_item.curve_z !== want.curve_z)
                    flag_field("curve_z", want.curve_z, out_item.curve_z);
                if (out_item.sample_number !== want.sample_number)
                    flag_field("sample_number", want.sample_number, out_item.sample_number);
                if (out_item.last_point !== want.last_point)
                    flag_field("last_point", want.last_point, out_item.last_point);
            end
        end
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no item moved for %0d cycles, %0d curve points outstanding",
                     $time, quiet_cycles, expected_points.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        int steps_plan [NUM_PHASES] = '{0, 1, 63, 5, 2, RANDOM_STEPS, 3, RANDOM_STEPS,
                                        63, 4, RANDOM_STEPS, 8};
        int phase_start;

        // directed rows, all at the reset setting of 50 steps
        // every point at the positive extreme gives the same point back
        for (int p = 0; p < NUM_POINTS; p++)
            add_row(p[1:0], COORD_MAX, COORD_MAX, COORD_MAX, p == NUM_POINTS - 1, COORD_MAX);
        // every point at the negative extreme
        for (int p = 0; p < NUM_POINTS; p++)
            add_row(p[1:0], COORD_MIN, COORD_MIN, COORD_MIN, p == NUM_POINTS - 1, COORD_MIN);
        // all zero
        for (int p = 0; p < NUM_POINTS; p++)
            add_row(p[1:0], '0, '0, '0, p == NUM_POINTS - 1, '0);
        // opposing extremes and alternating bit patterns
        add_row(2'd0, COORD_MIN, COORD_MAX, 32'hAAAA_AAAA, 1'b0, '0);
        add_row(2'd1, COORD_MAX, COORD_MIN, 32'h5555_5555, 1'b0, '0);
        add_row(2'd2, COORD_MIN, COORD_MAX, '0, 1'b0, '0);
        add_row(2'd3, COORD_MAX, COORD_MIN, '1, 1'b0, '0);
        // halfway ties in both signs at the mid sample
        add_row(2'd0, 32'sd4, -32'sd4, 32'sd12, 1'b0, '0);
        add_row(2'd1, '0, '0, '0, 1'b0, '0);
        add_row(2'd2, '0, '0, -32'sd1, 1'b0, '0);
        add_row(2'd3, '0, '0, 32'sd1, 1'b0, '0);
        // rerun with stored points, then a lone reload before another rerun
        add_row(2'd3, 32'h1234_5678, -32'sd305419896, 32'h0001_0000, 1'b0, '0);
        add_row(2'd1, 32'h7FFF_0000, 32'h8000_FFFF, 32'h0000_8000, 1'b0, '0);
        add_row(2'd3, 32'hFFFF_0000, 32'h0000_FFFF, 32'h4000_0000, 1'b0, '0);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_gaps = 1'b1;
        recv_gaps = 1'b1;
        foreach (dir_rows[i])
            send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].typed_val);
        drain_and_settle();

        // random phases over several step settings, the last one without idling
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            write_steps(STEP_WIDTH'((steps_plan[ph] == RANDOM_STEPS) ? $urandom_range(1, 10)
                                                                    : steps_plan[ph]));
            send_gaps = $urandom_range(0, 3) != 0;
            recv_gaps = $urandom_range(0, 3) != 0;
            no_idle = (ph == NUM_PHASES - 1);
            // one long receiver hold-off while the sender keeps offering items
            if (ph == 3)
                hold_req = 1'b1;
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
                send_random_group();
            drain_and_settle();
        end

        $display("covered %0d items and %0d runs, %0d curve points checked, steps 0 to 63",
                 items_sent, runs_started, points_checked);
        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
